/* design/gregorian_date_arithmetic_macros.svh */
// Assertion macros used by the date arithmetic checker.
`ifndef GREGORIAN_DATE_ARITHMETIC_MACROS_SVH
`define GREGORIAN_DATE_ARITHMETIC_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GDA_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GDA_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/gda_pkg.sv */
// Types, constants and helper functions of the Gregorian date arithmetic block.
package gda_pkg;

  localparam int unsigned DAY_W  = 5;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned YEAR_W = 14;
  localparam int unsigned ADD_W  = 16;
  localparam int unsigned DIFF_W = 23;
  localparam int unsigned ACC_W  = 25;

  localparam int unsigned MAX_YEAR_DEF = 9999;

  // Division by 100 through a reciprocal, exact for every 14-bit year.
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_100   = 5243;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned CENTURY     = 100;
  localparam int unsigned Q_W         = 8;
  localparam int unsigned R_W         = 7;
  localparam logic [R_W-1:0] CENTURY_LAST = R_W'(CENTURY - 1);

  localparam int unsigned MCNT_W = 4;
  localparam int unsigned TERM_W = 4;

  localparam logic [MON_W-1:0] MON_JAN = MON_W'(1);
  localparam logic [MON_W-1:0] MON_FEB = MON_W'(2);
  localparam logic [MON_W-1:0] MON_APR = MON_W'(4);
  localparam logic [MON_W-1:0] MON_JUN = MON_W'(6);
  localparam logic [MON_W-1:0] MON_SEP = MON_W'(9);
  localparam logic [MON_W-1:0] MON_NOV = MON_W'(11);
  localparam logic [MON_W-1:0] MON_DEC = MON_W'(12);

  localparam logic [DAY_W-1:0] DAYS_28 = DAY_W'(28);
  localparam logic [DAY_W-1:0] DAYS_29 = DAY_W'(29);
  localparam logic [DAY_W-1:0] DAYS_30 = DAY_W'(30);
  localparam logic [DAY_W-1:0] DAYS_31 = DAY_W'(31);

  // Year terms: 365 * p as shifted copies, then p/4 - p/100 + p/400.
  localparam logic [TERM_W-1:0] T_P256 = TERM_W'(0);
  localparam logic [TERM_W-1:0] T_P64  = TERM_W'(1);
  localparam logic [TERM_W-1:0] T_P32  = TERM_W'(2);
  localparam logic [TERM_W-1:0] T_P8   = TERM_W'(3);
  localparam logic [TERM_W-1:0] T_P4   = TERM_W'(4);
  localparam logic [TERM_W-1:0] T_P1   = TERM_W'(5);
  localparam logic [TERM_W-1:0] T_PD4  = TERM_W'(6);
  localparam logic [TERM_W-1:0] T_PQ   = TERM_W'(7);
  localparam logic [TERM_W-1:0] T_PQ4  = TERM_W'(8);

  localparam logic signed [ACC_W-1:0] DIFF_HI = ACC_W'((1 << (DIFF_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] DIFF_LO = ~DIFF_HI;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LDQ,
    S_LDR,
    S_DAY,
    S_MON,
    S_YEAR,
    S_WALK,
    S_DONE
  } gda_state_e;

  typedef enum logic [2:0] {
    OP_DAY,
    OP_ADD,
    OP_MCNT,
    OP_WALK,
    OP_YTERM
  } gda_op_e;

  typedef struct packed {
    logic              load;
    logic              sel_b;
    logic              ld_q;
    logic              ld_r;
    logic              acc_we;
    gda_op_e           op;
    logic              neg;
    logic              walk;
    logic [MCNT_W-1:0] mcnt;
    logic [TERM_W-1:0] term;
    logic              done;
  } gda_ctrl_t;

  typedef struct packed {
    logic             func;
    logic [MON_W-1:0] month;
    logic             year_zero;
    logic             walk_go;
  } gda_stat_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DAYS_30;
      MON_FEB: len = leap ? DAYS_29 : DAYS_28;
      default: len = DAYS_31;
    endcase
    return len;
  endfunction

endpackage

/* design/gregorian_date_arithmetic.sv */
// Gregorian date arithmetic: day difference of two dates, or days added to a date.
// One transaction at a time passes through a single shared adder under a small
// sequencer. For a difference, each date in turn loads its year split by 100,
// accumulates its day and one month length per earlier month, then the nine year
// terms (none for year zero); date b is added and date a subtracted. An addition
// loads the same split, adds add_days to the day and then subtracts one month length
// per cycle until the day fits or the year overflows. The result sits in an output
// register, so a new transaction is accepted while the previous result still waits
// to be taken.
module gregorian_date_arithmetic #(
  parameter int unsigned MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  logic [gda_pkg::DAY_W-1:0]         day_a_i,
  input  logic [gda_pkg::MON_W-1:0]         month_a_i,
  input  logic [gda_pkg::YEAR_W-1:0]        year_a_i,
  input  logic [gda_pkg::DAY_W-1:0]         day_b_i,
  input  logic [gda_pkg::MON_W-1:0]         month_b_i,
  input  logic [gda_pkg::YEAR_W-1:0]        year_b_i,
  input  logic [gda_pkg::ADD_W-1:0]         add_days_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [gda_pkg::DIFF_W-1:0] diff_days_o,
  output logic [gda_pkg::DAY_W-1:0]         res_day_o,
  output logic [gda_pkg::MON_W-1:0]         res_month_o,
  output logic [gda_pkg::YEAR_W-1:0]        res_year_o,
  output logic                              year_overflow_o
);
  import gda_pkg::*;

  gda_ctrl_t               ctrl;
  gda_stat_t               stat;
  logic                    out_free;
  logic                    out_valid_q, out_valid_d;
  logic signed [DIFF_W-1:0] diff_days;
  logic [DAY_W-1:0]        res_day;
  logic [MON_W-1:0]        res_month;
  logic [YEAR_W-1:0]       res_year;
  logic                    year_overflow;
  logic signed [DIFF_W-1:0] diff_days_q;
  logic [DAY_W-1:0]        res_day_q;
  logic [MON_W-1:0]        res_month_q;
  logic [YEAR_W-1:0]       res_year_q;
  logic                    year_overflow_q;

  assign out_free = !out_valid_q || out_ready_i;

  gda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  gda_dpath #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dpath (
    .clk_i           (clk_i),
    .ctrl_i          (ctrl),
    .func_i          (func_i),
    .day_a_i         (day_a_i),
    .month_a_i       (month_a_i),
    .year_a_i        (year_a_i),
    .day_b_i         (day_b_i),
    .month_b_i       (month_b_i),
    .year_b_i        (year_b_i),
    .add_days_i      (add_days_i),
    .stat_o          (stat),
    .diff_days_o     (diff_days),
    .res_day_o       (res_day),
    .res_month_o     (res_month),
    .res_year_o      (res_year),
    .year_overflow_o (year_overflow)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.done) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.done) begin
      diff_days_q     <= diff_days;
      res_day_q       <= res_day;
      res_month_q     <= res_month;
      res_year_q      <= res_year;
      year_overflow_q <= year_overflow;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign diff_days_o     = diff_days_q;
  assign res_day_o       = res_day_q;
  assign res_month_o     = res_month_q;
  assign res_year_o      = res_year_q;
  assign year_overflow_o = year_overflow_q;

endmodule

/* design/gda_ctrl.sv */
// Sequencer that steps the shared adder through serial counts and the month walk.
module gda_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                func_i,
  input  logic                out_free_i,
  input  gda_pkg::gda_stat_t  stat_i,
  output logic                in_ready_o,
  output gda_pkg::gda_ctrl_t  ctrl_o
);
  import gda_pkg::*;

  gda_state_e        state_q, state_d;
  logic              sel_b_q, sel_b_d;
  logic [MCNT_W-1:0] mcnt_q, mcnt_d;
  logic [TERM_W-1:0] term_q, term_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_b_q <= 1'b0;
      mcnt_q  <= '0;
      term_q  <= '0;
    end else begin
      state_q <= state_d;
      sel_b_q <= sel_b_d;
      mcnt_q  <= mcnt_d;
      term_q  <= term_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    sel_b_d     = sel_b_q;
    mcnt_d      = mcnt_q;
    term_d      = term_q;
    in_ready_o  = 1'b0;
    ctrl_o      = '0;
    ctrl_o.op   = OP_DAY;
    ctrl_o.sel_b = sel_b_q;
    ctrl_o.neg  = !sel_b_q;
    ctrl_o.mcnt = mcnt_q;
    ctrl_o.term = term_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          sel_b_d     = !func_i;
          state_d     = S_LDQ;
        end
      end
      S_LDQ: begin
        ctrl_o.ld_q = 1'b1;
        state_d     = S_LDR;
      end
      S_LDR: begin
        ctrl_o.ld_r = 1'b1;
        state_d     = S_DAY;
      end
      S_DAY: begin
        ctrl_o.acc_we = 1'b1;
        mcnt_d        = MCNT_W'(1);
        if (stat_i.func) begin
          ctrl_o.op  = OP_ADD;
          ctrl_o.neg = 1'b0;
          state_d    = S_WALK;
        end else begin
          ctrl_o.op = OP_DAY;
          state_d   = S_MON;
        end
      end
      S_MON: begin
        ctrl_o.op = OP_MCNT;
        if (mcnt_q < stat_i.month) begin
          ctrl_o.acc_we = 1'b1;
          mcnt_d        = mcnt_q + MCNT_W'(1);
        end else begin
          term_d  = T_P256;
          state_d = S_YEAR;
        end
      end
      S_YEAR: begin
        ctrl_o.op = OP_YTERM;
        if (stat_i.year_zero || term_q == T_PQ4) begin
          ctrl_o.acc_we = !stat_i.year_zero;
          if (sel_b_q) begin
            sel_b_d = 1'b0;
            state_d = S_LDQ;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          ctrl_o.acc_we = 1'b1;
          term_d        = term_q + TERM_W'(1);
        end
      end
      S_WALK: begin
        ctrl_o.op  = OP_WALK;
        ctrl_o.neg = 1'b1;
        if (stat_i.walk_go) begin
          ctrl_o.acc_we = 1'b1;
          ctrl_o.walk   = 1'b1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          ctrl_o.done = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* design/gda_dpath.sv */
// Datapath with the shared adder, the year-by-100 split and the walk counters.
module gda_dpath #(
  parameter int unsigned MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
  input  logic                              clk_i,
  input  gda_pkg::gda_ctrl_t                ctrl_i,
  input  logic                              func_i,
  input  logic [gda_pkg::DAY_W-1:0]         day_a_i,
  input  logic [gda_pkg::MON_W-1:0]         month_a_i,
  input  logic [gda_pkg::YEAR_W-1:0]        year_a_i,
  input  logic [gda_pkg::DAY_W-1:0]         day_b_i,
  input  logic [gda_pkg::MON_W-1:0]         month_b_i,
  input  logic [gda_pkg::YEAR_W-1:0]        year_b_i,
  input  logic [gda_pkg::ADD_W-1:0]         add_days_i,
  output gda_pkg::gda_stat_t                stat_o,
  output logic signed [gda_pkg::DIFF_W-1:0] diff_days_o,
  output logic [gda_pkg::DAY_W-1:0]         res_day_o,
  output logic [gda_pkg::MON_W-1:0]         res_month_o,
  output logic [gda_pkg::YEAR_W-1:0]        res_year_o,
  output logic                              year_overflow_o
);
  import gda_pkg::*;

  localparam int unsigned YR_W = ($clog2(MAX_YEAR + 2) > YEAR_W) ?
                                 $clog2(MAX_YEAR + 2) : YEAR_W;
  localparam logic [YR_W-1:0] MAX_YR = YR_W'(MAX_YEAR);

  logic                      func_q;
  logic [DAY_W-1:0]          da_q, db_q;
  logic [MON_W-1:0]          ma_q, mb_q;
  logic [YEAR_W-1:0]         ya_q, yb_q;
  logic [ADD_W-1:0]          add_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic [Q_W-1:0]            q_q;
  logic [R_W-1:0]            r_q;
  logic [MON_W-1:0]          mon_q;
  logic [YR_W-1:0]           yr_q;
  logic                      ovf_q;

  logic [DAY_W-1:0]          d_sel;
  logic [MON_W-1:0]          m_sel;
  logic [YEAR_W-1:0]         y_sel;
  logic [YEAR_W+RECIP_W-1:0] prod;
  logic [Q_W-1:0]            q_new;
  logic [YEAR_W-1:0]         q_x100;
  logic [YEAR_W-1:0]         rem;
  logic                      leap;
  logic [YEAR_W-1:0]         p;
  logic [Q_W-1:0]            pq;
  logic signed [ACC_W-1:0]   yterm;
  logic signed [ACC_W-1:0]   opnd;
  logic                      neg_eff;
  logic signed [ACC_W-1:0]   sum;
  logic [YR_W-1:0]           yr_inc;
  logic signed [ACC_W-1:0]   acc_sat;

  assign d_sel = ctrl_i.sel_b ? db_q : da_q;
  assign m_sel = ctrl_i.sel_b ? mb_q : ma_q;
  assign y_sel = ctrl_i.sel_b ? yb_q : ya_q;

  assign prod   = (YEAR_W+RECIP_W)'(y_sel) * (YEAR_W+RECIP_W)'(RECIP_100);
  assign q_new  = prod[RECIP_SHIFT +: Q_W];
  assign q_x100 = YEAR_W'(q_q) * YEAR_W'(CENTURY);
  assign rem    = y_sel - q_x100;

  assign leap = (r_q[1:0] == 2'b00) && ((r_q != '0) || (q_q[1:0] == 2'b00));
  assign p    = y_sel - YEAR_W'(1);
  assign pq   = (r_q == '0) ? q_q - Q_W'(1) : q_q;

  always_comb begin
    case (ctrl_i.term)
      T_P256:  yterm = ACC_W'(p) << 8;
      T_P64:   yterm = ACC_W'(p) << 6;
      T_P32:   yterm = ACC_W'(p) << 5;
      T_P8:    yterm = ACC_W'(p) << 3;
      T_P4:    yterm = ACC_W'(p) << 2;
      T_P1:    yterm = ACC_W'(p);
      T_PD4:   yterm = ACC_W'(p >> 2);
      T_PQ:    yterm = ACC_W'(pq);
      T_PQ4:   yterm = ACC_W'(pq >> 2);
      default: yterm = '0;
    endcase
  end

  always_comb begin
    unique case (ctrl_i.op)
      OP_DAY:   opnd = ACC_W'(d_sel);
      OP_ADD:   opnd = ACC_W'(add_q);
      OP_MCNT:  opnd = ACC_W'(month_len(ctrl_i.mcnt, leap));
      OP_WALK:  opnd = ACC_W'(month_len(mon_q, leap));
      OP_YTERM: opnd = yterm;
      default:  opnd = '0;
    endcase
  end

  assign neg_eff = ctrl_i.neg ^ ((ctrl_i.op == OP_YTERM) && (ctrl_i.term == T_PQ));
  assign sum     = neg_eff ? acc_q - opnd : acc_q + opnd;
  assign yr_inc  = yr_q + YR_W'(1);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      func_q <= func_i;
      da_q   <= day_a_i;
      ma_q   <= month_a_i;
      ya_q   <= year_a_i;
      db_q   <= day_b_i;
      mb_q   <= month_b_i;
      yb_q   <= year_b_i;
      add_q  <= add_days_i;
      acc_q  <= func_i ? ACC_W'(day_a_i) : '0;
      mon_q  <= month_a_i;
      yr_q   <= YR_W'(year_a_i);
      ovf_q  <= YR_W'(year_a_i) > MAX_YR;
    end else begin
      if (ctrl_i.acc_we) begin
        acc_q <= sum;
      end
      if (ctrl_i.ld_q) begin
        q_q <= q_new;
      end
      if (ctrl_i.ld_r) begin
        r_q <= rem[R_W-1:0];
      end
      if (ctrl_i.walk) begin
        if (mon_q >= MON_DEC) begin
          mon_q <= MON_JAN;
          yr_q  <= yr_inc;
          ovf_q <= yr_inc > MAX_YR;
          if (r_q == CENTURY_LAST) begin
            r_q <= '0;
            q_q <= q_q + Q_W'(1);
          end else begin
            r_q <= r_q + R_W'(1);
          end
        end else begin
          mon_q <= mon_q + MON_W'(1);
        end
      end
    end
  end

  assign stat_o.func      = func_q;
  assign stat_o.month     = m_sel;
  assign stat_o.year_zero = (y_sel == '0);
  assign stat_o.walk_go   = !ovf_q && !sum[ACC_W-1] && (sum != '0);

  always_comb begin
    if (acc_q > DIFF_HI) begin
      acc_sat = DIFF_HI;
    end else if (acc_q < DIFF_LO) begin
      acc_sat = DIFF_LO;
    end else begin
      acc_sat = acc_q;
    end
  end

  always_comb begin
    diff_days_o     = '0;
    res_day_o       = '0;
    res_month_o     = '0;
    res_year_o      = '0;
    year_overflow_o = 1'b0;
    if (!func_q) begin
      diff_days_o = acc_sat[DIFF_W-1:0];
    end else if (ovf_q) begin
      res_day_o       = DAYS_31;
      res_month_o     = MON_DEC;
      res_year_o      = MAX_YR[YEAR_W-1:0];
      year_overflow_o = 1'b1;
    end else begin
      res_day_o   = acc_q[DAY_W-1:0];
      res_month_o = mon_q;
      res_year_o  = yr_q[YEAR_W-1:0];
    end
  end

endmodule

/* design/gda_checker.sv */
// Port-level checker for the Gregorian date arithmetic block and its bind.
`include "gregorian_date_arithmetic_macros.svh"

module gda_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [gda_pkg::DIFF_W-1:0] diff_days_o,
  input logic [gda_pkg::DAY_W-1:0]         res_day_o,
  input logic [gda_pkg::MON_W-1:0]         res_month_o,
  input logic [gda_pkg::YEAR_W-1:0]        res_year_o,
  input logic                              year_overflow_o
);
  import gda_pkg::*;

  logic in_take;
  logic out_stall;
  logic ovf_shown;
  logic ovf_date;
  logic diff_shown;
  logic date_clear;

  assign in_take    = in_valid_i && in_ready_o;
  assign out_stall  = out_valid_o && !out_ready_i;
  assign ovf_shown  = out_valid_o && year_overflow_o;
  assign ovf_date   = (res_day_o == DAYS_31) && (res_month_o == MON_DEC) && (diff_days_o == '0);
  assign diff_shown = out_valid_o && (diff_days_o != '0);
  assign date_clear = (res_day_o == '0) && (res_month_o == '0) && (res_year_o == '0) &&
                      !year_overflow_o;

  // The sequencer works on a single transaction, so acceptance drops ready.
  `GDA_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_take, !in_ready_o, "ready after accept")

  // A result is held until the consumer takes it.
  `GDA_ASSERT_NXT(a_out_held, clk_i, rst_ni, out_stall, out_valid_o, "result dropped early")

  // A year overflow always reads as the last day of December.
  `GDA_ASSERT_IMP(a_ovf_date, clk_i, rst_ni, ovf_shown, ovf_date, "overflow date not saturated")

  // A nonzero difference comes from difference mode, which leaves the date fields clear.
  `GDA_ASSERT_IMP(a_diff_clean, clk_i, rst_ni, diff_shown, date_clear, "difference carries a date")

endmodule

bind gregorian_date_arithmetic gda_checker u_gda_checker (.*);

/* sim/tb_top.sv */
// Self-checking testbench for the Gregorian date difference and day addition block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gda_pkg::*;

  localparam logic FUNC_DIFF = 1'b0;
  localparam logic FUNC_ADD  = 1'b1;

  localparam longint      LAST_YEAR      = gda_pkg::MAX_YEAR_DEF;
  localparam longint      DIFF_SAT_HI    = longint'(2 ** (DIFF_W - 1)) - 1;
  localparam longint      DIFF_SAT_LO    = -DIFF_SAT_HI - 1;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 80;
  localparam int unsigned HOLD_CYCLES    = 400;

  typedef struct packed {
    logic              func;
    logic [DAY_W-1:0]  day_a;
    logic [MON_W-1:0]  month_a;
    logic [YEAR_W-1:0] year_a;
    logic [DAY_W-1:0]  day_b;
    logic [MON_W-1:0]  month_b;
    logic [YEAR_W-1:0] year_b;
    logic [ADD_W-1:0]  add_days;
  } date_req_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff_days;
    logic [DAY_W-1:0]         day;
    logic [MON_W-1:0]         month;
    logic [YEAR_W-1:0]        year;
    logic                     overflow;
  } date_res_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     func_i;
  logic [DAY_W-1:0]         day_a_i;
  logic [MON_W-1:0]         month_a_i;
  logic [YEAR_W-1:0]        year_a_i;
  logic [DAY_W-1:0]         day_b_i;
  logic [MON_W-1:0]         month_b_i;
  logic [YEAR_W-1:0]        year_b_i;
  logic [ADD_W-1:0]         add_days_i;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DIFF_W-1:0] diff_days_o;
  logic [DAY_W-1:0]         res_day_o;
  logic [MON_W-1:0]         res_month_o;
  logic [YEAR_W-1:0]        res_year_o;
  logic                     year_overflow_o;

  date_res_t   date_expect_q[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_wait = 0;
  int unsigned rx_hold_req = 0;
  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;

  gregorian_date_arithmetic dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .day_a_i        (day_a_i),
    .month_a_i      (month_a_i),
    .year_a_i       (year_a_i),
    .day_b_i        (day_b_i),
    .month_b_i      (month_b_i),
    .year_b_i       (year_b_i),
    .add_days_i     (add_days_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .diff_days_o    (diff_days_o),
    .res_day_o      (res_day_o),
    .res_month_o    (res_month_o),
    .res_year_o     (res_year_o),
    .year_overflow_o(year_overflow_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic bit leap_year(longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic longint days_in_month(logic [MON_W-1:0] m, longint y);
    case (m)
      MON_APR, MON_JUN, MON_SEP, MON_NOV: return 30;
      MON_FEB: return leap_year(y) ? 29 : 28;
      default: return 31;
    endcase
  endfunction

  function automatic longint day_number(logic [DAY_W-1:0] d, logic [MON_W-1:0] m,
                                        logic [YEAR_W-1:0] y);
    longint total;
    longint p;
    total = d;
    for (int i = 1; i < m; i++) total += days_in_month(MON_W'(i), y);
    if (y > 0) begin
      p = y - 1;
      total += p * 365 + p / 4 - p / 100 + p / 400;
    end
    return total;
  endfunction

  function automatic date_res_t predict_date(date_req_t r);
    date_res_t o;
    longint    diff;
    longint    day;
    longint    yr;
    int        mon;
    bit        ovf;
    o = '0;
    if (r.func == FUNC_DIFF) begin
      diff = day_number(r.day_b, r.month_b, r.year_b) - day_number(r.day_a, r.month_a, r.year_a);
      if (diff > DIFF_SAT_HI) diff = DIFF_SAT_HI;
      if (diff < DIFF_SAT_LO) diff = DIFF_SAT_LO;
      o.diff_days = diff[DIFF_W-1:0];
    end else begin
      day = r.day_a + r.add_days;
      mon = r.month_a;
      yr  = r.year_a;
      ovf = (yr > LAST_YEAR);
      while (!ovf && day > days_in_month(MON_W'(mon), yr)) begin
        day -= days_in_month(MON_W'(mon), yr);
        mon++;
        if (mon > MON_DEC) begin
          mon = MON_JAN;
          yr++;
          if (yr > LAST_YEAR) ovf = 1'b1;
        end
      end
      if (ovf) begin
        day = DAYS_31;
        mon = MON_DEC;
        yr  = LAST_YEAR;
      end
      o.day      = DAY_W'(day);
      o.month    = MON_W'(mon);
      o.year     = YEAR_W'(yr);
      o.overflow = ovf;
    end
    return o;
  endfunction

  function automatic int unsigned gap_length();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic date_req_t mk_diff(int da, int ma, int ya, int db, int mb, int yb);
    date_req_t r;
    r.func     = FUNC_DIFF;
    r.day_a    = DAY_W'(da);
    r.month_a  = MON_W'(ma);
    r.year_a   = YEAR_W'(ya);
    r.day_b    = DAY_W'(db);
    r.month_b  = MON_W'(mb);
    r.year_b   = YEAR_W'(yb);
    r.add_days = ADD_W'($urandom);
    return r;
  endfunction

  function automatic date_req_t mk_add(int da, int ma, int ya, int n);
    date_req_t r;
    r          = mk_diff(da, ma, ya, $urandom, $urandom, $urandom);
    r.func     = FUNC_ADD;
    r.add_days = ADD_W'(n);
    return r;
  endfunction

  function automatic date_req_t random_request();
    date_req_t r;
    r = '0;
    if ($urandom_range(0, 9) < 8) begin
      r.year_a  = YEAR_W'($urandom_range(1, LAST_YEAR));
      r.month_a = MON_W'($urandom_range(1, 12));
      r.day_a   = DAY_W'($urandom_range(1, days_in_month(r.month_a, r.year_a)));
      r.year_b  = YEAR_W'($urandom_range(1, LAST_YEAR));
      r.month_b = MON_W'($urandom_range(1, 12));
      r.day_b   = DAY_W'($urandom_range(1, days_in_month(r.month_b, r.year_b)));
    end else begin
      r.day_a   = DAY_W'($urandom);
      r.month_a = MON_W'($urandom);
      r.year_a  = YEAR_W'($urandom);
      r.day_b   = DAY_W'($urandom);
      r.month_b = MON_W'($urandom);
      r.year_b  = YEAR_W'($urandom);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: r.add_days = ADD_W'($urandom_range(0, 400));
      7, 8:                r.add_days = ADD_W'($urandom_range(0, 3000));
      default:             r.add_days = ADD_W'($urandom);
    endcase
    r.func = $urandom_range(0, 1) ? FUNC_ADD : FUNC_DIFF;
    return r;
  endfunction

  task automatic send_request(input date_req_t r);
    int unsigned gap;
    gap = tx_idle_on ? gap_length() : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= r.func;
    day_a_i    <= r.day_a;
    month_a_i  <= r.month_a;
    year_a_i   <= r.year_a;
    day_b_i    <= r.day_b;
    month_b_i  <= r.month_b;
    year_b_i   <= r.year_b;
    add_days_i <= r.add_days;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    date_expect_q.push_back(predict_date(r));
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    date_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (date_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual diff %0d date %0d/%0d/%0d",
                 $time, diff_days_o, res_day_o, res_month_o, res_year_o);
        mismatch_count++;
      end else begin
        want = date_expect_q.pop_front();
        check_field("diff_days", $signed(want.diff_days), diff_days_o);
        check_field("res_day", want.day, res_day_o);
        check_field("res_month", want.month, res_month_o);
        check_field("res_year", want.year, res_year_o);
        check_field("year_overflow", want.overflow, year_overflow_o);
      end
    end
  end

  always @(negedge clk_i) begin
    if (rx_hold_req != 0) begin
      rx_wait     = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_wait != 0) begin
      out_ready_i <= 1'b0;
      rx_wait--;
    end else begin
      out_ready_i <= 1'b1;
      if (rx_idle_on && $urandom_range(0, 3) == 0) rx_wait = gap_length();
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_directed_difference();
    send_request(mk_diff(1, 1, 2024, 1, 1, 2024));
    send_request(mk_diff(1, 1, 1, 31, 12, 9999));
    send_request(mk_diff(31, 12, 9999, 1, 1, 1));
    send_request(mk_diff(1, 1, 1, 31, 15, 16383));
    send_request(mk_diff(31, 15, 16383, 0, 0, 0));
    send_request(mk_diff(28, 2, 2000, 1, 3, 2000));
    send_request(mk_diff(28, 2, 1900, 1, 3, 1900));
    send_request(mk_diff(1, 1, 0, 1, 1, 1));
    send_request(mk_diff(0, 0, 2023, 31, 0, 2023));
    send_request(mk_diff(1, 13, 2023, 1, 15, 2023));
    send_request(mk_diff(31, 2, 2023, 1, 3, 2023));
    send_request(mk_diff(1, 3, 1600, 1, 3, 2400));
  endtask

  task automatic test_directed_addition();
    send_request(mk_add(15, 6, 2024, 0));
    send_request(mk_add(0, 5, 2024, 0));
    send_request(mk_add(31, 12, 9999, 1));
    send_request(mk_add(1, 1, 16383, 0));
    send_request(mk_add(1, 1, 1, 65535));
    send_request(mk_add(31, 15, 9999, 65535));
    send_request(mk_add(10, 0, 2023, 40));
    send_request(mk_add(5, 13, 2023, 30));
    send_request(mk_add(28, 2, 2000, 1));
    send_request(mk_add(28, 2, 1900, 1));
    send_request(mk_add(31, 1, 0, 29));
  endtask

  task automatic test_random_back_to_back(input int unsigned count);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (count) send_request(random_request());
  endtask

  task automatic test_random_with_gaps(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      send_request(random_request());
    end
  endtask

  task automatic test_output_backpressure(input int unsigned count);
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    rx_hold_req = HOLD_CYCLES;
    repeat (count) send_request(random_request());
    rx_idle_on = 1'b1;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    func_i      = FUNC_DIFF;
    day_a_i     = '0;
    month_a_i   = '0;
    year_a_i    = '0;
    day_b_i     = '0;
    month_b_i   = '0;
    year_b_i    = '0;
    add_days_i  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_difference();
    test_directed_addition();
    test_random_back_to_back(60);
    test_random_with_gaps(150);
    test_output_backpressure(40);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (date_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/gda_pkg.sv
design/gda_ctrl.sv
design/gda_dpath.sv
design/gregorian_date_arithmetic.sv
design/gda_checker.sv
sim/tb_top.sv
